// File: sv/pidc_pkg.sv
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int AccW  = 72;
    localparam int ProdW = 60;
    localparam int MulAW = 34;
    localparam int MulBW = 26;

    localparam logic [2:0] REG_GAINS_X   = 3'd0;
    localparam logic [2:0] REG_GAINS_Y   = 3'd1;
    localparam logic [2:0] REG_GAINS_Z   = 3'd2;
    localparam logic [2:0] REG_STEP      = 3'd3;
    localparam logic [2:0] REG_INV_STEP  = 3'd4;
    localparam logic [2:0] REG_SCALE_XY  = 3'd5;
    localparam logic [2:0] REG_SCALE_Z   = 3'd6;

    localparam logic [15:0] STEP_RST     = 16'd164;
    localparam logic [23:0] INV_STEP_RST = 24'd102400;
    localparam logic [15:0] SCALE_XY_RST = 16'd743;
    localparam logic [15:0] SCALE_Z_RST  = 16'd954;

    typedef logic signed [AccW-1:0] acc_t;

    function automatic logic signed [47:0] sat48(input acc_t v);
        if ((&v[AccW-1:47]) || !(|v[AccW-1:47]))
            return v[47:0];
        return v[AccW-1] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic signed [39:0] sat40(input acc_t v);
        if ((&v[AccW-1:39]) || !(|v[AccW-1:39]))
            return v[39:0];
        return v[AccW-1] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32(input acc_t v);
        if ((&v[AccW-1:31]) || !(|v[AccW-1:31]))
            return v[31:0];
        return v[AccW-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    endfunction

endpackage

// File: sv/pidc_mul.sv
`timescale 1ns / 1ps

module pidc_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [pidc_pkg::MulAW-1:0]   a,
    input  logic signed [pidc_pkg::MulBW-1:0]   b,
    output logic signed [pidc_pkg::ProdW-1:0]   prod
);
    import pidc_pkg::*;

    logic signed [ProdW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// File: sv/three_axis_pid_position_control_core.sv
`timescale 1ns / 1ps

// channel  | handshake                    | payload
// ---------+------------------------------+-----------------------------------------
// in       | in_valid / in_ready          | measured_x/y/z, target_x/y/z, yaw_cos/sin
// out      | out_valid / out_ready        | forward/lateral/throttle_command
// cfg      | cfg_write (no wait)          | cfg_index, cfg_data
//
// Each item runs 35 products through one 34x26 multiplier, each a multiply phase
// followed by an accumulate phase. in_ready is low while busy.
// A finished result sits in the output register; the next item may start then.
// A new result waits in the last step while the previous one is not taken.
// Reset clears integrals, previous errors and restores register defaults.

module three_axis_pid_position_control_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measured_x,
    input  logic signed [31:0] measured_y,
    input  logic signed [31:0] measured_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [15:0] yaw_cos,
    input  logic signed [15:0] yaw_sin,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] forward_command,
    output logic signed [31:0] lateral_command,
    output logic signed [31:0] throttle_command,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data
);
    import pidc_pkg::*;

    localparam logic [1:0] AX_ROT = 2'd3;

    localparam logic [3:0] S_INT = 4'd0;
    localparam logic [3:0] S_DER = 4'd1;
    localparam logic [3:0] S_P   = 4'd2;
    localparam logic [3:0] S_IH  = 4'd3;
    localparam logic [3:0] S_IL  = 4'd4;
    localparam logic [3:0] S_DH  = 4'd5;
    localparam logic [3:0] S_DL  = 4'd6;
    localparam logic [3:0] S_SH  = 4'd7;
    localparam logic [3:0] S_SL  = 4'd8;

    localparam logic [3:0] R_XC_H = 4'd0;
    localparam logic [3:0] R_XC_L = 4'd1;
    localparam logic [3:0] R_YS_H = 4'd2;
    localparam logic [3:0] R_YS_L = 4'd3;
    localparam logic [3:0] R_YC_H = 4'd4;
    localparam logic [3:0] R_YC_L = 4'd5;
    localparam logic [3:0] R_XS_H = 4'd6;
    localparam logic [3:0] R_XS_L = 4'd7;

    logic [47:0] gains_x_reg, gains_y_reg, gains_z_reg;
    logic [15:0] step_reg, scale_xy_reg, scale_z_reg;
    logic [23:0] inv_step_reg;

    logic signed [31:0] meas_reg [3];
    logic signed [31:0] tgt_reg  [3];
    logic signed [15:0] cos_reg, sin_reg;

    logic signed [47:0] integ_reg [3];
    logic signed [32:0] prev_reg  [3];
    logic signed [39:0] n_reg     [3];
    logic signed [47:0] der_reg, f_reg;
    acc_t               acc_reg, facc_reg;
    logic signed [31:0] fwd_tmp_reg;

    logic       busy_reg, phase_reg;
    logic [1:0] ax_reg;
    logic [3:0] sub_reg;

    logic               out_valid_reg;
    logic signed [31:0] fwd_reg, lat_reg, thr_reg;

    logic [1:0]              ax_i;
    logic signed [32:0]      e_cur;
    logic signed [33:0]      de_cur;
    logic [47:0]             gains_sel;
    logic [15:0]             kp, ki, kd, scale_sel, k_sel;
    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic signed [ProdW-1:0] prod;
    acc_t                    p72, p_hi, lo_sum, f_sum;
    logic signed [47:0]      hi_src;
    logic signed [39:0]      nx, ny;
    logic                    last_step, stall, advance;

    assign ax_i      = (ax_reg == AX_ROT) ? 2'd0 : ax_reg;
    assign e_cur     = 33'(meas_reg[ax_i]) - 33'(tgt_reg[ax_i]);
    assign de_cur    = 34'(e_cur) - 34'(prev_reg[ax_i]);
    assign gains_sel = (ax_i == 2'd0) ? gains_x_reg :
                       (ax_i == 2'd1) ? gains_y_reg : gains_z_reg;
    assign kp        = gains_sel[15:0];
    assign ki        = gains_sel[31:16];
    assign kd        = gains_sel[47:32];
    assign scale_sel = (ax_i == 2'd2) ? scale_z_reg : scale_xy_reg;
    assign nx        = n_reg[0];
    assign ny        = n_reg[1];

    always_comb
    begin
        hi_src = integ_reg[ax_i];
        k_sel  = ki;
        mul_a  = '0;
        mul_b  = '0;
        if (ax_reg != AX_ROT)
        begin
            case (sub_reg)
                S_DH, S_DL:
                begin
                    hi_src = der_reg;
                    k_sel  = kd;
                end
                S_SH, S_SL:
                begin
                    hi_src = f_reg;
                    k_sel  = scale_sel;
                end
                default:
                begin
                    hi_src = integ_reg[ax_i];
                    k_sel  = ki;
                end
            endcase
            case (sub_reg)
                S_INT:
                begin
                    mul_a = MulAW'(e_cur);
                    mul_b = MulBW'({1'b0, step_reg});
                end
                S_DER:
                begin
                    mul_a = de_cur;
                    mul_b = MulBW'({1'b0, inv_step_reg});
                end
                S_P:
                begin
                    mul_a = MulAW'(e_cur);
                    mul_b = MulBW'({1'b0, kp});
                end
                S_IH, S_DH, S_SH:
                begin
                    mul_a = MulAW'($signed(hi_src[47:24]));
                    mul_b = MulBW'({1'b0, k_sel});
                end
                S_IL, S_DL, S_SL:
                begin
                    mul_a = MulAW'({1'b0, hi_src[23:0]});
                    mul_b = MulBW'({1'b0, k_sel});
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else
        begin
            case (sub_reg)
                R_XC_H:
                begin
                    mul_a = MulAW'($signed(nx[39:24]));
                    mul_b = MulBW'(cos_reg);
                end
                R_XC_L:
                begin
                    mul_a = MulAW'({1'b0, nx[23:0]});
                    mul_b = MulBW'(cos_reg);
                end
                R_YS_H:
                begin
                    mul_a = MulAW'($signed(ny[39:24]));
                    mul_b = MulBW'(sin_reg);
                end
                R_YS_L:
                begin
                    mul_a = MulAW'({1'b0, ny[23:0]});
                    mul_b = MulBW'(sin_reg);
                end
                R_YC_H:
                begin
                    mul_a = MulAW'($signed(ny[39:24]));
                    mul_b = MulBW'(cos_reg);
                end
                R_YC_L:
                begin
                    mul_a = MulAW'({1'b0, ny[23:0]});
                    mul_b = MulBW'(cos_reg);
                end
                R_XS_H:
                begin
                    mul_a = MulAW'($signed(nx[39:24]));
                    mul_b = -MulBW'(sin_reg);
                end
                R_XS_L:
                begin
                    mul_a = MulAW'({1'b0, nx[23:0]});
                    mul_b = -MulBW'(sin_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    pidc_mul u_mul (
        .clk  (clk),
        .en   (busy_reg && !phase_reg),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign p72    = AccW'(prod);
    assign p_hi   = p72 <<< 24;
    assign lo_sum = acc_reg + p72;
    assign f_sum  = facc_reg + (lo_sum >>> 8);

    assign last_step = (ax_reg == AX_ROT) && (sub_reg == R_XS_L);
    assign stall     = phase_reg && last_step && out_valid_reg && !out_ready;
    assign advance   = busy_reg && phase_reg && !stall;
    assign in_ready  = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_x_reg  <= '0;
            gains_y_reg  <= '0;
            gains_z_reg  <= '0;
            step_reg     <= STEP_RST;
            inv_step_reg <= INV_STEP_RST;
            scale_xy_reg <= SCALE_XY_RST;
            scale_z_reg  <= SCALE_Z_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAINS_X:  gains_x_reg  <= cfg_data;
                REG_GAINS_Y:  gains_y_reg  <= cfg_data;
                REG_GAINS_Z:  gains_z_reg  <= cfg_data;
                REG_STEP:     step_reg     <= cfg_data[15:0];
                REG_INV_STEP: inv_step_reg <= cfg_data[23:0];
                REG_SCALE_XY: scale_xy_reg <= cfg_data[15:0];
                REG_SCALE_Z:  scale_z_reg  <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            ax_reg        <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_valid && in_ready)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                ax_reg    <= '0;
                sub_reg   <= '0;
            end
            else if (busy_reg && !phase_reg)
            begin
                phase_reg <= 1'b1;
            end
            else if (advance)
            begin
                phase_reg <= 1'b0;
                if (ax_reg != AX_ROT)
                begin
                    if (sub_reg == S_INT)
                    begin
                        integ_reg[ax_i] <= sat48(AccW'(integ_reg[ax_i]) + (p72 >>> 16));
                    end
                    if (sub_reg == S_DER)
                    begin
                        prev_reg[ax_i] <= e_cur;
                    end
                    if (sub_reg == S_SL)
                    begin
                        sub_reg <= '0;
                        ax_reg  <= ax_reg + 2'd1;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 4'd1;
                    end
                end
                else if (last_step)
                begin
                    busy_reg      <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    sub_reg <= sub_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg[0] <= measured_x;
            meas_reg[1] <= measured_y;
            meas_reg[2] <= measured_z;
            tgt_reg[0]  <= target_x;
            tgt_reg[1]  <= target_y;
            tgt_reg[2]  <= target_z;
            cos_reg     <= yaw_cos;
            sin_reg     <= yaw_sin;
        end
        if (advance)
        begin
            if (ax_reg != AX_ROT)
            begin
                case (sub_reg)
                    S_DER:             der_reg  <= sat48(p72 >>> 8);
                    S_P:               facc_reg <= p72 >>> 8;
                    S_IH, S_DH, S_SH:  acc_reg  <= p_hi;
                    S_IL:              facc_reg <= f_sum;
                    S_DL:              f_reg    <= sat48(f_sum);
                    S_SL:              n_reg[ax_i] <= sat40(lo_sum >>> 16);
                    default:           ;
                endcase
            end
            else
            begin
                case (sub_reg)
                    R_XC_H, R_YC_H:    acc_reg <= p_hi;
                    R_XC_L, R_YC_L:    acc_reg <= lo_sum;
                    R_YS_H, R_XS_H:    acc_reg <= acc_reg + p_hi;
                    R_YS_L:            fwd_tmp_reg <= sat32(lo_sum >>> 14);
                    R_XS_L:
                    begin
                        fwd_reg <= fwd_tmp_reg;
                        lat_reg <= sat32(lo_sum >>> 14);
                        thr_reg <= sat32(AccW'(n_reg[2]));
                    end
                    default:           ;
                endcase
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign forward_command  = fwd_reg;
    assign lateral_command  = lat_reg;
    assign throttle_command = thr_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> busy_reg && !phase_reg && ax_reg == 2'd0 && sub_reg == 4'd0)
        else $error("item accepted without starting the sequence");

    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (ax_reg != AX_ROT && sub_reg <= S_SL) ||
                     (ax_reg == AX_ROT && sub_reg <= R_XS_L))
        else $error("sequencer step out of range");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_step |=> out_valid_reg && !busy_reg)
        else $error("last step did not publish a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(fwd_reg) && $stable(lat_reg))
        else $error("pending result overwritten");

endmodule

// File: tb/tb_three_axis_pid_position_control_core.sv
`timescale 1ns / 1ps

module tb_three_axis_pid_position_control_core;
    import pidc_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         STALL_LIMIT = 4000;
    localparam int         RANDOM_PER_PHASE = 150;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] meas [3];
        logic signed [31:0] targ [3];
        logic signed [15:0] cosv;
        logic signed [15:0] sinv;
    } position_item_t;

    typedef struct {
        logic signed [31:0] fwd;
        logic signed [31:0] lat;
        logic signed [31:0] thr;
    } command_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] measured_x = '0, measured_y = '0, measured_z = '0;
    logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
    logic signed [15:0] yaw_cos = '0, yaw_sin = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] forward_command, lateral_command, throttle_command;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [47:0]        cfg_data = '0;

    three_axis_pid_position_control_core u_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor copy of registers and state
    logic [47:0]  gains [3];
    logic [15:0]  step_reg;
    logic [23:0]  inv_step_reg;
    logic [15:0]  scale_xy_reg, scale_z_reg;
    wide_t        integ [3];
    wide_t        prev_err [3];

    position_item_t pending_items [$];
    command_t       expected_commands [$];
    int             mismatches = 0;
    int             commands_seen = 0;
    int             items_sent = 0;
    bit             idle_enable = 1'b1;
    bit             in_taken = 1'b0;
    bit             out_taken = 1'b0;

    function automatic wide_t clamp(wide_t v, int bits);
        wide_t hi, lo;
        hi = (wide_t'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic wide_t axis_command(int axis, wide_t e, logic [47:0] g,
                                           logic [15:0] scale);
        wide_t kp, ki, kd, st, ist, sc, der, f;
        kp  = wide_t'($signed({1'b0, g[15:0]}));
        ki  = wide_t'($signed({1'b0, g[31:16]}));
        kd  = wide_t'($signed({1'b0, g[47:32]}));
        st  = wide_t'($signed({1'b0, step_reg}));
        ist = wide_t'($signed({1'b0, inv_step_reg}));
        sc  = wide_t'($signed({1'b0, scale}));
        integ[axis] = clamp(integ[axis] + ((e * st) >>> 16), 48);
        der = clamp(((e - prev_err[axis]) * ist) >>> 8, 48);
        prev_err[axis] = e;
        f = clamp(((kp * e) >>> 8) + ((ki * integ[axis]) >>> 8) + ((kd * der) >>> 8), 48);
        return clamp((f * sc) >>> 16, 40);
    endfunction

    function automatic command_t predict_command(position_item_t it);
        command_t r;
        wide_t    e [3];
        wide_t    n [3];
        wide_t    c, s;
        for (int a = 0; a < 3; a++)
            e[a] = wide_t'(it.meas[a]) - wide_t'(it.targ[a]);
        c = wide_t'(it.cosv);
        s = wide_t'(it.sinv);
        n[0] = axis_command(0, e[0], gains[0], scale_xy_reg);
        n[1] = axis_command(1, e[1], gains[1], scale_xy_reg);
        n[2] = axis_command(2, e[2], gains[2], scale_z_reg);
        r.fwd = 32'(clamp((n[0] * c + n[1] * s) >>> 14, 32));
        r.lat = 32'(clamp((n[1] * c - n[0] * s) >>> 14, 32));
        r.thr = 32'(clamp(n[2], 32));
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GAINS_X:  gains[0] = val;
            REG_GAINS_Y:  gains[1] = val;
            REG_GAINS_Z:  gains[2] = val;
            REG_STEP:     step_reg = val[15:0];
            REG_INV_STEP: inv_step_reg = val[23:0];
            REG_SCALE_XY: scale_xy_reg = val[15:0];
            REG_SCALE_Z:  scale_z_reg = val[15:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic position_item_t random_item();
        position_item_t it;
        int             mode;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++)
        begin
            if (mode < 2)
            begin
                it.meas[a] = $urandom();
                it.targ[a] = $urandom();
            end
            else
            begin
                it.targ[a] = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
                it.meas[a] = it.targ[a] + ($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            end
        end
        if ($urandom_range(0, 9) < 8)
        begin
            it.cosv = 16'($signed($urandom_range(0, 32768)) - 16384);
            it.sinv = 16'($signed($urandom_range(0, 32768)) - 16384);
        end
        else
        begin
            it.cosv = 16'($urandom());
            it.sinv = 16'($urandom());
        end
        return it;
    endfunction

    function automatic position_item_t make_item(logic signed [31:0] m, logic signed [31:0] t,
                                                 logic signed [15:0] c, logic signed [15:0] s);
        position_item_t it;
        for (int a = 0; a < 3; a++)
        begin
            it.meas[a] = m;
            it.targ[a] = t;
        end
        it.cosv = c;
        it.sinv = s;
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_enable) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    int in_gap = 0;
    int out_gap = 0;

    // driver: hold until accepted, then advance
    always @(negedge clk)
    begin
        position_item_t it;
        if (in_valid && !in_taken)
        begin
        end
        else if (in_gap > 0)
        begin
            in_gap <= in_gap - 1;
            in_valid <= 1'b0;
        end
        else if (pending_items.size() > 0 && rst_n)
        begin
            it = pending_items.pop_front();
            measured_x <= it.meas[0];
            measured_y <= it.meas[1];
            measured_z <= it.meas[2];
            target_x <= it.targ[0];
            target_y <= it.targ[1];
            target_z <= it.targ[2];
            yaw_cos <= it.cosv;
            yaw_sin <= it.sinv;
            in_valid <= 1'b1;
            in_gap <= pick_gap();
        end
        else
            in_valid <= 1'b0;

        if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            out_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        position_item_t it;
        command_t       exp_cmd;
        in_taken  = in_valid && in_ready;
        out_taken = out_valid && out_ready;
        if (in_taken)
        begin
            it.meas[0] = measured_x;
            it.meas[1] = measured_y;
            it.meas[2] = measured_z;
            it.targ[0] = target_x;
            it.targ[1] = target_y;
            it.targ[2] = target_z;
            it.cosv = yaw_cos;
            it.sinv = yaw_sin;
            expected_commands.push_back(predict_command(it));
            items_sent++;
        end
        if (out_taken)
        begin
            commands_seen++;
            if (expected_commands.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected item fwd=%0d lat=%0d thr=%0d", $time,
                         forward_command, lateral_command, throttle_command);
            end
            else
            begin
                exp_cmd = expected_commands.pop_front();
                if (forward_command !== exp_cmd.fwd)
                begin
                    mismatches++;
                    $display("%0t: forward_command expected %0d actual %0d", $time,
                             exp_cmd.fwd, forward_command);
                end
                if (lateral_command !== exp_cmd.lat)
                begin
                    mismatches++;
                    $display("%0t: lateral_command expected %0d actual %0d", $time,
                             exp_cmd.lat, lateral_command);
                end
                if (throttle_command !== exp_cmd.thr)
                begin
                    mismatches++;
                    $display("%0t: throttle_command expected %0d actual %0d", $time,
                             exp_cmd.thr, throttle_command);
                end
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_items.size() == 0 && !in_valid && expected_commands.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_all(logic [47:0] gx, logic [47:0] gy, logic [47:0] gz, logic [47:0] st,
                           logic [47:0] ist, logic [47:0] sxy, logic [47:0] sz);
        write_reg(REG_GAINS_X, gx);
        write_reg(REG_GAINS_Y, gy);
        write_reg(REG_GAINS_Z, gz);
        write_reg(REG_STEP, st);
        write_reg(REG_INV_STEP, ist);
        write_reg(REG_SCALE_XY, sxy);
        write_reg(REG_SCALE_Z, sz);
        write_reg(REG_UNUSED, rand48());
        end_writes();
    endtask

    localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;

    initial
    begin
        gains = '{default: '0};
        step_reg = STEP_RST;
        inv_step_reg = INV_STEP_RST;
        scale_xy_reg = SCALE_XY_RST;
        scale_z_reg = SCALE_Z_RST;
        integ = '{default: '0};
        prev_err = '{default: '0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults with zero gains, then gains on top of reset timing
        pending_items.push_back(make_item(32'sd65536, 32'sd0, 16'sd16384, 16'sd0));
        drain();
        write_reg(REG_GAINS_X, 48'h0180_0040_0200);
        write_reg(REG_GAINS_Y, 48'h0100_0020_0300);
        write_reg(REG_GAINS_Z, 48'h0200_0010_0100);
        end_writes();
        pending_items.push_back(make_item(PMAX, PMIN, 16'sd16384, 16'sd0));
        pending_items.push_back(make_item(PMIN, PMAX, 16'sd0, 16'sd16384));
        pending_items.push_back(make_item(PMAX, PMAX, -16'sd16384, 16'sd0));
        pending_items.push_back(make_item(PMIN, PMIN, 16'sd0, -16'sd16384));
        pending_items.push_back(make_item(32'sd0, 32'sd0, 16'sh7FFF, 16'sh8000));
        pending_items.push_back(make_item(-32'sd1, 32'sd0, 16'sh8000, 16'sh7FFF));
        pending_items.push_back(make_item(32'sd1, -32'sd1, 16'sd11585, 16'sd11585));
        pending_items.push_back(make_item(PMAX, PMIN, 16'sh7FFF, 16'sh7FFF));
        pending_items.push_back(make_item(PMAX, PMIN, 16'sh8000, 16'sh8000));
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            idle_enable = (ph != 2);
            case (ph)
                0: set_all(rand48(), rand48(), rand48(), STEP_RST, INV_STEP_RST,
                           SCALE_XY_RST, SCALE_Z_RST);
                1: set_all('1, '1, '1, '1, '1, '1, '1);
                2: set_all('0, '0, '0, 48'hFFFF_FFFF_0000, 48'hFFFF_FF00_0000,
                           48'h1234_5678_0000, 48'hFFFF_FFFF_0000);
                3: set_all(48'h0001_0001_0001, 48'hFFFF_0000_FFFF, 48'h0000_FFFF_0000,
                           48'd1, 48'd1, 48'd1, 48'd1);
                default: set_all(rand48(), rand48(), rand48(), rand48(), rand48(),
                                 rand48(), rand48());
            endcase
            if (ph == 1)
            begin
                pending_items.push_back(make_item(PMAX, PMIN, 16'sd16384, -16'sd16384));
                pending_items.push_back(make_item(PMIN, PMAX, -16'sd16384, 16'sd16384));
                pending_items.push_back(make_item(PMAX, PMIN, 16'sh8000, 16'sh7FFF));
            end
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
                pending_items.push_back(random_item());
            drain();
        end

        $display("covered %0d items over 9 register settings incl. all-ones and all-zero",
                 items_sent);
        $display("checked %0d command items, %0d mismatches", commands_seen, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
